/* src/aabb_pkg.sv */
// ----------------------------------------------------------------------------
// aabb_pkg
// Shared constants and types for the affine box bounds unit.
// ----------------------------------------------------------------------------
package aabb_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int COORD_W    = 32;
   localparam int AXES       = 3;
   localparam int ROW_COUNT  = 3;
   localparam int ROW_SEL_W  = 2;
   localparam int PROD_W     = 2 * COORD_W;
   localparam int SUM_W      = PROD_W + 2;

   localparam int REQ_DATA_W = 10 * COORD_W;
   localparam int REQ_USER_W = 1 + ROW_SEL_W;
   localparam int RSP_DATA_W = 6 * COORD_W;
   localparam int RSP_USER_W = 1;

   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_BOX  = 1'b1;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic signed [SUM_W-1:0]   sum_type;

   typedef struct packed {
      logic      sat;
      coord_type value;
   } clamp_type;

endpackage

/* src/aabb_affine_transform_bounds_unit.sv */
// ----------------------------------------------------------------------------
// aabb_affine_transform_bounds_unit
// Maps an axis-aligned box through a 3x4 affine matrix, returns tight bounds.
// ----------------------------------------------------------------------------
// Takes one beat per cycle when rsp_tready does not stall the pipeline. A load
// beat (tuser action 0) writes one matrix row at acceptance and gives no
// result; a box beat (action 1) gives one result through four register stages:
// eighteen 32x32 products, min/max per product pair, a four-operand sum per
// output coordinate, then the fixed-point shift and 32-bit clamp into the
// output register. Each stage only holds while the stage after it is full and
// stalled, so bubbles are absorbed. A box sees every load accepted before it.
module aabb_affine_transform_bounds_unit
   import aabb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // coef_x, coef_y, coef_z, coef_offset, box_min_x, box_min_y, box_min_z,
   // box_max_x, box_max_y, box_max_z
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // action, row_select
   input  logic [REQ_USER_W-1:0] req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // out_min_x, out_min_y, out_min_z, out_max_x, out_max_y, out_max_z
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // saturated
   output logic [RSP_USER_W-1:0] rsp_tuser
);

   function automatic clamp_type clamp_coord(input sum_type s);
      sum_type   shr;
      clamp_type c;
      shr     = s >>> FRAC_BITS;
      c.sat   = 1'b0;
      c.value = coord_type'(shr);
      if (shr > SUM_W'(signed'({1'b0, {(COORD_W-1){1'b1}}}))) begin
         c.sat   = 1'b1;
         c.value = {1'b0, {(COORD_W-1){1'b1}}};
      end else if (shr < SUM_W'(signed'({1'b1, {(COORD_W-1){1'b0}}}))) begin
         c.sat   = 1'b1;
         c.value = {1'b1, {(COORD_W-1){1'b0}}};
      end
      return c;
   endfunction

   logic                 action;
   logic [ROW_SEL_W-1:0] row_sel;
   coord_type            coef_in  [0:AXES];
   coord_type            box_min  [0:AXES-1];
   coord_type            box_max  [0:AXES-1];

   assign action  = req_tuser[0];
   assign row_sel = req_tuser[ROW_SEL_W:1];

   for (genvar k = 0; k <= AXES; k++) begin : g_coef
      assign coef_in[k] = req_tdata[COORD_W*k +: COORD_W];
   end
   for (genvar k = 0; k < AXES; k++) begin : g_box
      assign box_min[k] = req_tdata[COORD_W*(4+k) +: COORD_W];
      assign box_max[k] = req_tdata[COORD_W*(7+k) +: COORD_W];
   end

   // handshake chain
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic rdy1, rdy2, rdy3, rdy4;
   logic load_fire, box_fire;

   assign rdy4       = !v4_ff || rsp_tready;
   assign rdy3       = !v3_ff || rdy4;
   assign rdy2       = !v2_ff || rdy3;
   assign rdy1       = !v1_ff || rdy2;
   assign req_tready = rdy1;
   assign load_fire  = req_tvalid && req_tready && (action == ACT_LOAD);
   assign box_fire   = req_tvalid && req_tready && (action == ACT_BOX);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= box_fire;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
      end
   end

   // matrix rows
   coord_type coef_ff [0:ROW_COUNT-1][0:AXES];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < ROW_COUNT; r++) begin
            for (int k = 0; k <= AXES; k++) begin
               coef_ff[r][k] <= '0;
            end
         end
      end else if (load_fire && (row_sel < ROW_SEL_W'(ROW_COUNT))) begin
         for (int k = 0; k <= AXES; k++) begin
            coef_ff[row_sel][k] <= coef_in[k];
         end
      end
   end

   // stage 1: products
   prod_type  pa_ff  [0:ROW_COUNT-1][0:AXES-1];
   prod_type  pb_ff  [0:ROW_COUNT-1][0:AXES-1];
   coord_type off1_ff [0:ROW_COUNT-1];

   always_ff @(posedge clock) begin
      if (rdy1 && box_fire) begin
         for (int r = 0; r < ROW_COUNT; r++) begin
            for (int k = 0; k < AXES; k++) begin
               pa_ff[r][k] <= PROD_W'(coef_ff[r][k]) * PROD_W'(box_min[k]);
               pb_ff[r][k] <= PROD_W'(coef_ff[r][k]) * PROD_W'(box_max[k]);
            end
            off1_ff[r] <= coef_ff[r][AXES];
         end
      end
   end

   // stage 2: order each product pair
   prod_type  lo_ff   [0:ROW_COUNT-1][0:AXES-1];
   prod_type  hi_ff   [0:ROW_COUNT-1][0:AXES-1];
   coord_type off2_ff [0:ROW_COUNT-1];

   always_ff @(posedge clock) begin
      if (rdy2 && v1_ff) begin
         for (int r = 0; r < ROW_COUNT; r++) begin
            for (int k = 0; k < AXES; k++) begin
               if (pa_ff[r][k] < pb_ff[r][k]) begin
                  lo_ff[r][k] <= pa_ff[r][k];
                  hi_ff[r][k] <= pb_ff[r][k];
               end else begin
                  lo_ff[r][k] <= pb_ff[r][k];
                  hi_ff[r][k] <= pa_ff[r][k];
               end
            end
            off2_ff[r] <= off1_ff[r];
         end
      end
   end

   // stage 3: full-width sums with translation
   sum_type sum_lo_ff [0:ROW_COUNT-1];
   sum_type sum_hi_ff [0:ROW_COUNT-1];

   always_ff @(posedge clock) begin
      if (rdy3 && v2_ff) begin
         for (int r = 0; r < ROW_COUNT; r++) begin
            sum_lo_ff[r] <= SUM_W'(lo_ff[r][0]) + SUM_W'(lo_ff[r][1])
                          + SUM_W'(lo_ff[r][2]) + (SUM_W'(off2_ff[r]) <<< FRAC_BITS);
            sum_hi_ff[r] <= SUM_W'(hi_ff[r][0]) + SUM_W'(hi_ff[r][1])
                          + SUM_W'(hi_ff[r][2]) + (SUM_W'(off2_ff[r]) <<< FRAC_BITS);
         end
      end
   end

   // stage 4: shift, clamp, output register
   clamp_type cl_lo [0:ROW_COUNT-1];
   clamp_type cl_hi [0:ROW_COUNT-1];
   logic      sat_in;
   coord_type min_ff [0:ROW_COUNT-1];
   coord_type max_ff [0:ROW_COUNT-1];
   logic      sat_ff;

   always_comb begin
      sat_in = 1'b0;
      for (int r = 0; r < ROW_COUNT; r++) begin
         cl_lo[r] = clamp_coord(sum_lo_ff[r]);
         cl_hi[r] = clamp_coord(sum_hi_ff[r]);
         sat_in   = sat_in | cl_lo[r].sat | cl_hi[r].sat;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy4 && v3_ff) begin
         for (int r = 0; r < ROW_COUNT; r++) begin
            min_ff[r] <= cl_lo[r].value;
            max_ff[r] <= cl_hi[r].value;
         end
         sat_ff <= sat_in;
      end
   end

   for (genvar r = 0; r < ROW_COUNT; r++) begin : g_out
      assign rsp_tdata[COORD_W*r +: COORD_W]             = min_ff[r];
      assign rsp_tdata[COORD_W*(ROW_COUNT+r) +: COORD_W] = max_ff[r];
   end

   assign rsp_tuser  = sat_ff;
   assign rsp_tvalid = v4_ff;

endmodule
